/* hw/rtl/ipsd_pkg.sv */
// shared types, constants and the microcode table of the incremental pid pwm drive
`timescale 1ns / 1ps
`default_nettype none

package ipsd_pkg;

  // stream and configuration widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_DIR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FLOOR  = 3'd6;

  // register reset values
  localparam logic [15:0] GAIN_P_RST     = 16'd2048;
  localparam logic [15:0] GAIN_I_RST     = 16'd819;
  localparam logic [15:0] GAIN_D_RST     = 16'd41;
  localparam logic [15:0] PWM_PERIOD_RST = 16'd60000;
  localparam logic [15:0] FULL_SCALE_RST = 16'd350;
  localparam logic        MIRROR_DIR_RST = 1'b0;
  localparam logic        INV_FLOOR_RST  = 1'b1;

  // 16*60/(pi*64) in q16: mm/s to 1/16 rpm
  localparam logic [18:0] RPM16_PER_MMPS_Q16 = 19'd312912;

  // bit-serial divider
  localparam int             DIV_STEPS = 16;
  localparam int             DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // microprogram addresses
  localparam int             PC_W    = 4;
  localparam logic [PC_W-1:0] UA_WAIT = 4'd0;
  localparam logic [PC_W-1:0] UA_DIV  = 4'd13;

  typedef enum logic [1:0] {MA_TGT, MA_DIFF, MA_ERR, MA_MAG} mula_t;
  typedef enum logic [2:0] {MB_K, MB_GP, MB_GI, MB_GD, MB_PERIOD} mulb_t;
  typedef enum logic [1:0] {SUM_HOLD, SUM_LOAD, SUM_ADD} sumop_t;
  typedef enum logic [3:0] {
    DP_NOP, DP_ERR, DP_DIFF_P, DP_DIFF_D, DP_ROUND, DP_ACC, DP_MAG,
    DP_DIV_INIT, DP_DIV_STEP, DP_RESULT
  } dpop_t;
  typedef enum logic [2:0] {C_NEXT, C_WAIT_IN, C_DIV_LOOP, C_WAIT_OUT, C_JUMP} cond_t;

  typedef struct packed {
    mula_t           mula;
    mulb_t           mulb;
    logic            mul_en;
    sumop_t          sumop;
    dpop_t           dpop;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // one control word per step
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] step);
    uword_t w;
    w = '{mula: MA_TGT, mulb: MB_K, mul_en: 1'b0, sumop: SUM_HOLD,
          dpop: DP_NOP, cond: C_NEXT, target: UA_WAIT};
    case (step)
      4'd0: begin
        w.cond = C_WAIT_IN;
      end
      4'd1: begin
        w.mul_en = 1'b1; w.mula = MA_TGT; w.mulb = MB_K;
      end
      4'd2: begin
        w.dpop = DP_ERR;
      end
      4'd3: begin
        w.dpop = DP_DIFF_P;
      end
      4'd4: begin
        w.mul_en = 1'b1; w.mula = MA_DIFF; w.mulb = MB_GP; w.dpop = DP_DIFF_D;
      end
      4'd5: begin
        w.mul_en = 1'b1; w.mula = MA_DIFF; w.mulb = MB_GD; w.sumop = SUM_LOAD;
      end
      4'd6: begin
        w.mul_en = 1'b1; w.mula = MA_ERR; w.mulb = MB_GI; w.sumop = SUM_ADD;
      end
      4'd7: begin
        w.sumop = SUM_ADD;
      end
      4'd8: begin
        w.dpop = DP_ROUND;
      end
      4'd9: begin
        w.dpop = DP_ACC;
      end
      4'd10: begin
        w.dpop = DP_MAG;
      end
      4'd11: begin
        w.mul_en = 1'b1; w.mula = MA_MAG; w.mulb = MB_PERIOD;
      end
      4'd12: begin
        w.dpop = DP_DIV_INIT;
      end
      4'd13: begin
        w.dpop = DP_DIV_STEP; w.cond = C_DIV_LOOP; w.target = UA_DIV;
      end
      4'd14: begin
        w.dpop = DP_RESULT; w.cond = C_WAIT_OUT; w.target = UA_WAIT;
      end
      default: begin
        w.cond = C_JUMP; w.target = UA_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/incremental_pid_speed_pwm_drive.sv */
// top level: microcoded incremental pid speed controller with pwm compare output
// an item passes the fixed steps and then the divider loop before out_tvalid
// the sequencer holds one item at a time
// a finished item waits in the output register while the next item is taken in
// reset (rst_n low, synchronous) clears pid state, sequencer and output valid, loads defaults
`timescale 1ns / 1ps
`default_nettype none

module incremental_pid_speed_pwm_drive (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: target_speed [15:0], measured_speed [31:16]
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ipsd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // out_tdata: pwm_compare [15:0], direction_level [16], controller_output [48:17], zeros above
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ipsd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ipsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ipsd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ipsd_pkg::*;

  // configuration registers
  logic [15:0] gain_p_r, gain_i_r, gain_d_r, period_r, full_scale_r;
  logic        mirror_r, floor_r;

  // sequencer
  logic [PC_W-1:0]      pc_r, pc_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  uword_t               uw;

  // pid state
  logic signed [18:0] e1_r, e2_r;
  logic signed [31:0] acc_r, acc_nxt;

  // datapath registers
  logic signed [15:0] tgt_r, meas_r;
  logic signed [48:0] prod_r;
  logic signed [18:0] err_r, err_nxt;
  logic signed [20:0] d_r, d_nxt;
  logic signed [39:0] sum_r;
  logic signed [27:0] inc_r, inc_nxt;
  logic [31:0]        mag_r, mag_nxt;
  logic               pos_r, pos_nxt;
  logic [19:0]        rem_r, rem_nxt;
  logic [15:0]        qn_r;
  logic               qbit;
  logic               ovf_r;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // shared multiplier operands
  logic signed [32:0] mul_a;
  logic [18:0]        mul_b;
  logic signed [52:0] mul_full;

  // scratch
  logic [48:0]        p_mag, p_rnd;
  logic signed [19:0] t16, err_wide;
  logic [39:0]        s_mag, s_rnd;
  logic signed [32:0] acc_sum;
  logic [15:0]        fs_eff;
  logic [19:0]        den;
  logic [20:0]        trial;
  logic [16:0]        up;
  logic [15:0]        cmp;
  logic               level;
  logic               in_fire, out_free, res_fire;

  assign uw        = ucode_rom(pc_r);
  assign in_tready = (uw.cond == C_WAIT_IN);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign res_fire  = (uw.dpop == DP_RESULT) && out_free;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // operand selection for the one multiplier
  always_comb begin
    case (uw.mula)
      MA_TGT:  mul_a = {{17{tgt_r[15]}}, tgt_r};
      MA_DIFF: mul_a = {{12{d_r[20]}}, d_r};
      MA_ERR:  mul_a = {{14{err_r[18]}}, err_r};
      MA_MAG:  mul_a = {1'b0, mag_r};
      default: mul_a = '0;
    endcase
    case (uw.mulb)
      MB_K:      mul_b = RPM16_PER_MMPS_Q16;
      MB_GP:     mul_b = {3'b0, gain_p_r};
      MB_GI:     mul_b = {3'b0, gain_i_r};
      MB_GD:     mul_b = {3'b0, gain_d_r};
      MB_PERIOD: mul_b = {3'b0, period_r};
      default:   mul_b = '0;
    endcase
  end

  assign mul_full = mul_a * $signed({1'b0, mul_b});

  // target in 1/16 rpm, rounded half away from zero, then the error
  always_comb begin
    p_mag    = prod_r[48] ? (49'd0 - prod_r) : prod_r;
    p_rnd    = p_mag + 49'd32768;
    t16      = prod_r[48] ? (20'sd0 - $signed(p_rnd[35:16])) : $signed(p_rnd[35:16]);
    err_wide = t16 - {{4{meas_r[15]}}, meas_r};
    err_nxt  = err_wide[18:0];
  end

  // first and second error differences share one register
  always_comb begin
    if (uw.dpop == DP_DIFF_D) begin
      d_nxt = {{2{err_r[18]}}, err_r} - {{1{e1_r[18]}}, e1_r, 1'b0}
            + {{2{e2_r[18]}}, e2_r};
    end else begin
      d_nxt = {{2{err_r[18]}}, err_r} - {{2{e1_r[18]}}, e1_r};
    end
  end

  // increment: sum >> 12 rounded half away from zero
  always_comb begin
    s_mag   = sum_r[39] ? (40'd0 - sum_r) : sum_r;
    s_rnd   = s_mag + 40'd2048;
    inc_nxt = sum_r[39] ? (28'sd0 - $signed(s_rnd[39:12])) : $signed(s_rnd[39:12]);
  end

  // saturating accumulate
  always_comb begin
    acc_sum = {acc_r[31], acc_r} + {{5{inc_r[27]}}, inc_r};
    if (acc_sum[32] != acc_sum[31]) begin
      acc_nxt = acc_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      acc_nxt = acc_sum[31:0];
    end
  end

  // magnitude on the driven side; zero target counts as negative
  always_comb begin
    pos_nxt = !tgt_r[15] && (tgt_r != 16'sd0);
    if (pos_nxt) begin
      mag_nxt = acc_r[31] ? 32'd0 : acc_r;
    end else begin
      mag_nxt = acc_r[31] ? (32'd0 - acc_r) : 32'd0;
    end
  end

  // restoring divider step by 16 * full scale, a zero full scale taken as one
  always_comb begin
    fs_eff  = (full_scale_r == 16'd0) ? 16'd1 : full_scale_r;
    den     = {fs_eff, 4'b0};
    trial   = {rem_r, qn_r[15]};
    qbit    = (trial >= {1'b0, den});
    rem_nxt = qbit ? 20'(trial - {1'b0, den}) : trial[19:0];
  end

  // compare value from quotient, remainder and direction
  always_comb begin
    level = pos_r ^ mirror_r;
    up    = {1'b0, qn_r} + {16'd0, (rem_r != 20'd0)};
    if (level) begin
      if (ovf_r || (up > {1'b0, period_r})) begin
        cmp = {15'd0, floor_r};
      end else begin
        cmp = period_r - up[15:0];
      end
      if (cmp > period_r) begin
        cmp = period_r;
      end
    end else begin
      if (ovf_r || (qn_r > period_r)) begin
        cmp = period_r;
      end else begin
        cmp = qn_r;
      end
    end
  end

  // step counter with conditional jumps
  always_comb begin
    case (uw.cond)
      C_NEXT:     pc_nxt = pc_r + 1'b1;
      C_WAIT_IN:  pc_nxt = in_fire ? (pc_r + 1'b1) : pc_r;
      C_DIV_LOOP: pc_nxt = (div_cnt_r == DIV_LAST) ? (pc_r + 1'b1) : uw.target;
      C_WAIT_OUT: pc_nxt = out_free ? uw.target : pc_r;
      C_JUMP:     pc_nxt = uw.target;
      default:    pc_nxt = UA_WAIT;
    endcase
  end

  always_comb begin
    if (res_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state, pid state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= UA_WAIT;
      div_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      e1_r         <= '0;
      e2_r         <= '0;
      acc_r        <= '0;
      gain_p_r     <= GAIN_P_RST;
      gain_i_r     <= GAIN_I_RST;
      gain_d_r     <= GAIN_D_RST;
      period_r     <= PWM_PERIOD_RST;
      full_scale_r <= FULL_SCALE_RST;
      mirror_r     <= MIRROR_DIR_RST;
      floor_r      <= INV_FLOOR_RST;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (uw.dpop == DP_DIV_INIT) begin
        div_cnt_r <= '0;
      end else if (uw.dpop == DP_DIV_STEP) begin
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      if (uw.dpop == DP_ACC) begin
        acc_r <= acc_nxt;
        e2_r  <= e1_r;
        e1_r  <= err_r;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_P:     gain_p_r     <= cfg_data;
          REG_GAIN_I:     gain_i_r     <= cfg_data;
          REG_GAIN_D:     gain_d_r     <= cfg_data;
          REG_PWM_PERIOD: period_r     <= cfg_data;
          REG_FULL_SCALE: full_scale_r <= cfg_data;
          REG_MIRROR_DIR: mirror_r     <= cfg_data[0];
          REG_INV_FLOOR:  floor_r      <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // datapath payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tgt_r  <= in_tdata[15:0];
      meas_r <= in_tdata[31:16];
    end
    if (uw.mul_en) begin
      prod_r <= mul_full[48:0];
    end
    case (uw.sumop)
      SUM_LOAD: sum_r <= prod_r[39:0];
      SUM_ADD:  sum_r <= sum_r + prod_r[39:0];
      default:  ;
    endcase
    case (uw.dpop)
      DP_ERR:    err_r <= err_nxt;
      DP_DIFF_P: d_r   <= d_nxt;
      DP_DIFF_D: d_r   <= d_nxt;
      DP_ROUND:  inc_r <= inc_nxt;
      DP_MAG: begin
        mag_r <= mag_nxt;
        pos_r <= pos_nxt;
      end
      DP_DIV_INIT: begin
        // quotient overflows 16 bits exactly when the high part reaches the divisor
        ovf_r <= (prod_r[47:16] >= {12'd0, den});
        rem_r <= prod_r[35:16];
        qn_r  <= prod_r[15:0];
      end
      DP_DIV_STEP: begin
        rem_r <= rem_nxt;
        qn_r  <= {qn_r[14:0], qbit};
      end
      default: ;
    endcase
    if (res_fire) begin
      out_data_r <= {7'd0, acc_r, level, cmp};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ipsd_checker.sv */
// port-level checker for the incremental pid pwm drive, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ipsd_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [ipsd_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // only one item in work: taking an item closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while an item is in work");

  // an item needs many cycles: no fresh result right after one is taken in
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

  // reset empties the output
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind incremental_pid_speed_pwm_drive ipsd_checker u_ipsd_checker (.*);

`default_nettype wire

/* dv/tb_incremental_pid_speed_pwm_drive.sv */
// self-checking testbench for the incremental pid speed controller with pwm compare output
`timescale 1ns / 1ps

module tb_incremental_pid_speed_pwm_drive;
  import ipsd_pkg::*;

  // index past the end of the register map, writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  // mm/s to 1/16 rpm, 16*60/(pi*64) held in q16
  localparam longint MMPS_TO_RPM16_Q16 = 312912;
  localparam int LONG_HOLD = 300;
  // a little over the latency of one item
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    shortint target_speed;
    shortint measured_speed;
  } speed_item_t;

  typedef struct packed {
    logic [15:0] pwm_compare;
    logic        direction_level;
    int          controller_output;
  } drive_result_t;

  typedef enum logic {SHAPE_MIXED, SHAPE_WINDUP} speed_shape_t;

  typedef struct {
    speed_item_t   item;
    bit            typed;
    drive_result_t want;
  } directed_row_t;

  localparam drive_result_t NO_CHECK = '0;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;   // target_speed [15:0], measured_speed [31:16]
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;  // pwm_compare [15:0], direction_level [16],
                                       // controller_output [48:17], zeros above
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  // shadow copy of the registers and the loop state
  logic [15:0] gain_p_q, gain_i_q, gain_d_q, period_q, full_scale_q;
  logic        mirror_q, floor_q;
  int          err_prev, err_prev2, acc_out;

  drive_result_t drive_expected [$];
  int            mismatch_count = 0;
  bit            stall_en = 1'b1;
  bit            hold_req = 1'b0;

  // directed items: extremes, zero target, wrong-side output, inverted floor
  directed_row_t directed_rows [22] = '{
    '{'{0, 0}, 1'b1, '{16'd0, 1'b0, 0}},          // fresh from reset, nothing moves
    '{'{0, 0}, 1'b1, '{16'd0, 1'b0, 0}},
    '{'{1, 0}, 1'b0, NO_CHECK},
    '{'{-1, 0}, 1'b0, NO_CHECK},
    '{'{0, 1}, 1'b0, NO_CHECK},
    '{'{0, -1}, 1'b0, NO_CHECK},
    '{'{32767, -32768}, 1'b0, NO_CHECK},          // big output, inverted form below zero
    '{'{32767, -32768}, 1'b0, NO_CHECK},
    '{'{32767, -32768}, 1'b0, NO_CHECK},
    '{'{0, 0}, 1'b0, NO_CHECK},                   // zero target with a positive output
    '{'{32767, 32767}, 1'b0, NO_CHECK},
    '{'{-32768, 32767}, 1'b0, NO_CHECK},
    '{'{-32768, 32767}, 1'b0, NO_CHECK},
    '{'{-32768, -32768}, 1'b0, NO_CHECK},
    '{'{0, -32768}, 1'b0, NO_CHECK},
    '{'{-1, 32767}, 1'b0, NO_CHECK},
    '{'{1, -32768}, 1'b0, NO_CHECK},
    '{'{16, 76}, 1'b0, NO_CHECK},
    '{'{-16, -76}, 1'b0, NO_CHECK},
    '{'{32767, 0}, 1'b0, NO_CHECK},
    '{'{-32768, 0}, 1'b0, NO_CHECK},
    '{'{0, 0}, 1'b0, NO_CHECK}
  };

  incremental_pid_speed_pwm_drive DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // round to nearest, ties away from zero
  function automatic longint round_shr(input longint v, input int s);
    longint mag;
    longint r;
    mag = (v < 0) ? -v : v;
    r = (mag + (longint'(1) << (s - 1))) >>> s;
    return (v < 0) ? -r : r;
  endfunction

  function automatic int sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // one control step: pid increment, direction and compare for one item
  function automatic drive_result_t compute_drive(input speed_item_t it);
    drive_result_t res;
    longint tgt, e, e1, e2, sum, inc, acc, mag, den, num, up, cmp;
    bit     pos, lvl;
    tgt = it.target_speed;
    e   = round_shr(tgt * MMPS_TO_RPM16_Q16, 16) - longint'(it.measured_speed);
    e1  = err_prev;
    e2  = err_prev2;
    sum = longint'(gain_p_q) * (e - e1) + longint'(gain_i_q) * e
        + longint'(gain_d_q) * (e - 2 * e1 + e2);
    inc = round_shr(sum, 12);
    acc_out   = sat32(longint'(acc_out) + inc);
    err_prev2 = err_prev;
    err_prev  = sat32(e);

    // zero target counts as the negative side
    pos = (tgt > 0);
    lvl = pos ^ mirror_q;
    acc = acc_out;
    // output on the wrong side of the target counts as zero
    if (pos) mag = (acc > 0) ? acc : 0;
    else     mag = (acc < 0) ? -acc : 0;

    den = 16 * ((full_scale_q == 16'd0) ? 64'sd1 : longint'(full_scale_q));
    num = mag * longint'(period_q);
    if (lvl) begin
      up  = (num + den - 1) / den;
      cmp = (up > longint'(period_q)) ? longint'(floor_q) : longint'(period_q) - up;
    end else begin
      cmp = num / den;
    end
    if (cmp > longint'(period_q)) cmp = longint'(period_q);

    res.pwm_compare       = cmp[15:0];
    res.direction_level   = lvl;
    res.controller_output = acc_out;
    return res;
  endfunction

  function automatic speed_item_t draw_speeds(input speed_shape_t shape);
    speed_item_t it;
    int          sel;
    shortint     edges [5];
    edges = '{-32768, -1, 0, 1, 32767};
    sel = $urandom_range(0, 15);
    if (shape == SHAPE_WINDUP) begin
      // drive the accumulator into its ceiling, with the odd noisy item
      if (sel != 0) begin
        it.target_speed   = 32767;
        it.measured_speed = -32768;
      end else begin
        it.target_speed   = shortint'($urandom_range(16384, 32767));
        it.measured_speed = shortint'($urandom);
      end
    end else if (sel < 2) begin
      it.target_speed   = shortint'($urandom);
      it.measured_speed = shortint'($urandom);
    end else if (sel < 4) begin
      it.target_speed   = edges[$urandom_range(0, 4)];
      it.measured_speed = edges[$urandom_range(0, 4)];
    end else begin
      // plausible loop: measured speed tracks the converted target with some noise
      it.target_speed   = shortint'(int'($urandom_range(0, 4000)) - 2000);
      it.measured_speed = shortint'((int'(it.target_speed) * 305) / 64
                                    + int'($urandom_range(0, 1600)) - 800);
    end
    return it;
  endfunction

  task automatic flag_mismatch(input string what, input longint want, input longint seen);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, seen);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GAIN_P:     gain_p_q     = val;
      REG_GAIN_I:     gain_i_q     = val;
      REG_GAIN_D:     gain_d_q     = val;
      REG_PWM_PERIOD: period_q     = val;
      REG_FULL_SCALE: full_scale_q = val;
      REG_MIRROR_DIR: mirror_q     = val[0];
      REG_INV_FLOOR:  floor_q      = val[0];
      default: ;
    endcase
  endtask

  // the one-bit registers get junk in their upper bits, which must be ignored
  task automatic set_drive_config(input logic [15:0] gp, input logic [15:0] gi,
                                  input logic [15:0] gd, input logic [15:0] period,
                                  input logic [15:0] full_scale, input logic mirror,
                                  input logic inv_floor);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_PWM_PERIOD, period);
    write_reg(REG_FULL_SCALE, full_scale);
    write_reg(REG_MIRROR_DIR, {15'($urandom), mirror});
    write_reg(REG_INV_FLOOR, {15'($urandom), inv_floor});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input speed_item_t it, input bit typed, input drive_result_t want);
    drive_result_t predicted;
    int            gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {it.measured_speed, it.target_speed};
    do @(posedge clk); while (!in_tready);
    predicted = compute_drive(it);
    drive_expected.push_back(typed ? want : predicted);
    // random sender gap, junk on the data lines while valid is low
    if (stall_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic run_items(input int count, input speed_shape_t shape);
    repeat (count) send_item(draw_speeds(shape), 1'b0, NO_CHECK);
  endtask

  // stop offering items and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
  endtask

  // result side: random back-pressure bursts, plus one long hold-off on request
  initial begin : result_sink
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    drive_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (drive_expected.size() == 0) begin
        flag_mismatch("unexpected result, out_tdata", 0, longint'(out_tdata));
      end else begin
        want = drive_expected.pop_front();
        if (out_tdata[15:0] !== want.pwm_compare)
          flag_mismatch("pwm_compare", want.pwm_compare, out_tdata[15:0]);
        if (out_tdata[16] !== want.direction_level)
          flag_mismatch("direction_level", want.direction_level, out_tdata[16]);
        if (out_tdata[48:17] !== want.controller_output)
          flag_mismatch("controller_output", want.controller_output,
                        longint'($signed(out_tdata[48:17])));
        if (out_tdata[OUT_TDATA_W-1:49] !== '0)
          flag_mismatch("padding", 0, out_tdata[OUT_TDATA_W-1:49]);
      end
    end
  end

  // run time guard, several times the slowest legal run
  initial begin : run_guard
    #5_000_000;
    $display("incremental_pid_speed_pwm_drive regression: fail");
    $finish;
  end

  initial begin : stimulus
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;

    gain_p_q     = GAIN_P_RST;
    gain_i_q     = GAIN_I_RST;
    gain_d_q     = GAIN_D_RST;
    period_q     = PWM_PERIOD_RST;
    full_scale_q = FULL_SCALE_RST;
    mirror_q     = MIRROR_DIR_RST;
    floor_q      = INV_FLOOR_RST;
    err_prev     = 0;
    err_prev2    = 0;
    acc_out      = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed items under the reset defaults
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // defaults, with a long hold-off on the result side so the input backs up
    run_items(60, SHAPE_MIXED);
    hold_req = 1'b1;
    run_items(70, SHAPE_MIXED);

    // all gains at zero: the output freezes; widest period, narrowest scale
    drain_results();
    set_drive_config(16'd0, 16'd0, 16'd0, 16'd65535, 16'd1, 1'b1, 1'b0);
    run_items(100, SHAPE_MIXED);

    // all gains at maximum: wind the accumulator up into saturation
    drain_results();
    set_drive_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd65535, 1'b0, 1'b1);
    run_items(800, SHAPE_WINDUP);

    // zero period and zero full scale, plus a write past the register map
    drain_results();
    set_drive_config(16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)),
                     16'($urandom_range(0, 8191)), 16'd0, 16'd0, 1'b1, 1'b1);
    write_reg(REG_SPARE, 16'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
    run_items(100, SHAPE_MIXED);

    repeat (3) begin
      drain_results();
      set_drive_config(16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)),
                       16'($urandom_range(0, 8191)), 16'($urandom_range(1, 65535)),
                       16'($urandom_range(1, 2000)), 1'($urandom), 1'($urandom));
      run_items(80, SHAPE_MIXED);
    end

    // closing stretch back near the defaults, no idling on either side
    drain_results();
    stall_en = 1'b0;
    set_drive_config(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, PWM_PERIOD_RST, FULL_SCALE_RST,
                     1'($urandom), INV_FLOOR_RST);
    run_items(150, SHAPE_MIXED);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && drive_expected.size() == 0)
      $display("incremental_pid_speed_pwm_drive regression: pass");
    else
      $display("incremental_pid_speed_pwm_drive regression: fail");
    $finish;
  end

endmodule

/* incremental_pid_speed_pwm_drive.f */
hw/rtl/ipsd_pkg.sv
hw/rtl/incremental_pid_speed_pwm_drive.sv
hw/rtl/ipsd_checker.sv
dv/tb_incremental_pid_speed_pwm_drive.sv
